// ===== rtl/bqdf2_pkg.sv =====
// Package for the direct form II biquad filter unit.
// Holds fixed widths, register index codes and the sequencer state type.
// No dependencies.
package bqdf2_pkg;

  // Fixed field widths
  localparam int COEF_W    = 32;  // coefficient registers
  localparam int DELAY_W   = 32;  // delay words w1 / w2
  localparam int CHAN_W    = 1;   // channel field
  localparam int CFG_IDX_W = 3;   // configuration register index
  localparam int PROD_W    = 2 * COEF_W;
  // Accumulator: three full products plus the scaled sample never wrap here
  localparam int ACC_W     = PROD_W + 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,  // waiting for a word
    ST_FB1   = 8'b0000_0010,  // delay words arrive, a1*w1
    ST_FB2   = 8'b0000_0100,  // a2*w2
    ST_FF1   = 8'b0000_1000,  // b1*w1
    ST_FF2   = 8'b0001_0000,  // b2*w2, w is settled
    ST_FF0   = 8'b0010_0000,  // b0*w, delay write-back
    ST_DRAIN = 8'b0100_0000,  // last product into accumulator
    ST_OUT   = 8'b1000_0000   // load output register
  } state_t;

endpackage

// ===== rtl/biquad_direct_form_two_filter_unit.sv =====
// Biquad IIR section, direct form II, with per-channel delay words. Depends on bqdf2_pkg.
// One word is in flight at a time: the single shared 32x32 multiplier does five products in
// sequence, and the next word is taken once the result moves to the output register.
// Reset (rst, synchronous) clears all delay words through per-channel valid bits;
// coefficients reset to b0 = 1.0, others 0.
module biquad_direct_form_two_filter_unit #(
  parameter int CHANNELS       = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [bqdf2_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bqdf2_pkg::COEF_W-1:0]          cfg_data,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // sample_in
  input  logic [bqdf2_pkg::CHAN_W-1:0]          s_axis_tuser,   // channel_in
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,   // sample_out
  output logic [bqdf2_pkg::CHAN_W-1:0]          m_axis_tuser    // channel_out
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ACC_W   = bqdf2_pkg::ACC_W;
  localparam int DW      = bqdf2_pkg::DELAY_W;
  localparam int CW      = bqdf2_pkg::COEF_W;
  localparam int PW      = bqdf2_pkg::PROD_W;

  localparam logic [ACC_W-1:0] ROUND_C = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [CW-1:0]    B0_RST  = CW'(64'd1 << COEF_FRAC_BITS);

  bqdf2_pkg::state_t state;

  // coefficient registers
  logic signed [CW-1:0] b0, b1, b2, a1, a2;

  // delay memory: entry holds {w2, w1}
  logic [2*DW-1:0]     dmem [CHANNELS];
  logic [CHANNELS-1:0] dvalid;
  logic [2*DW-1:0]     rd_q;
  logic                rd_valid;

  // per-word registers
  logic [IDX_W-1:0]              idx;
  logic [bqdf2_pkg::CHAN_W-1:0]  chan;
  logic signed [DW-1:0]          w1, w2, w;
  logic signed [ACC_W-1:0]       acc_fb, acc_ff;
  logic signed [PW-1:0]          prod;
  logic signed [CW-1:0]          op_coef;
  logic signed [DW-1:0]          op_data;

  logic                          in_acc;
  logic [IDX_W-1:0]              in_idx;
  logic [SAMPLE_BITS-1:0]        in_x;
  logic signed [DW-1:0]          w1_rd, w2_rd;
  logic signed [ACC_W-1:0]       prod_ext;
  logic signed [ACC_W-1:0]       fb_sh, ff_sh;
  logic [DW-1:0]                 w_sat;
  logic [SAMPLE_BITS-1:0]        y_sat;
  logic                          out_free;
  logic [SAMPLE_BITS-1:0]        y_q;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_idx   = (CHANNELS > 1) ? IDX_W'(s_axis_tuser) : '0;
  assign in_x     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == bqdf2_pkg::ST_IDLE);

  // unwritten entries read as zero
  assign w1_rd = rd_valid ? rd_q[DW-1:0] : '0;
  assign w2_rd = rd_valid ? rd_q[2*DW-1:DW] : '0;
  assign prod_ext = {{(ACC_W-PW){prod[PW-1]}}, prod};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b0 <= B0_RST;
      b1 <= '0;
      b2 <= '0;
      a1 <= '0;
      a2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bqdf2_pkg::REG_B0: b0 <= cfg_data;
        bqdf2_pkg::REG_B1: b1 <= cfg_data;
        bqdf2_pkg::REG_B2: b2 <= cfg_data;
        bqdf2_pkg::REG_A1: a1 <= cfg_data;
        bqdf2_pkg::REG_A2: a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // delay memory: read on accept, write back in ST_FF0
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q <= dmem[in_idx];
    end
    if (state == bqdf2_pkg::ST_FF0) begin
      dmem[idx] <= {w1, w};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid   <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_valid <= dvalid[in_idx];
      end
      if (state == bqdf2_pkg::ST_FF0) begin
        dvalid[idx] <= 1'b1;
      end
    end
  end

  // multiplier operand select
  always_comb begin
    op_coef = a1;
    op_data = w1_rd;
    case (state)
      bqdf2_pkg::ST_FB1: begin op_coef = a1; op_data = w1_rd; end
      bqdf2_pkg::ST_FB2: begin op_coef = a2; op_data = w2;    end
      bqdf2_pkg::ST_FF1: begin op_coef = b1; op_data = w1;    end
      bqdf2_pkg::ST_FF2: begin op_coef = b2; op_data = w2;    end
      bqdf2_pkg::ST_FF0: begin op_coef = b0; op_data = w;     end
      default: begin op_coef = a1; op_data = w1; end
    endcase
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= op_coef * op_data;
  end

  // round-shift and clamp of both sums
  assign fb_sh = acc_fb >>> COEF_FRAC_BITS;
  assign ff_sh = acc_ff >>> COEF_FRAC_BITS;

  always_comb begin
    if ((&fb_sh[ACC_W-1:DW-1]) || !(|fb_sh[ACC_W-1:DW-1])) begin
      w_sat = fb_sh[DW-1:0];
    end else begin
      w_sat = fb_sh[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_comb begin
    if ((&ff_sh[ACC_W-1:SAMPLE_BITS-1]) || !(|ff_sh[ACC_W-1:SAMPLE_BITS-1])) begin
      y_sat = ff_sh[SAMPLE_BITS-1:0];
    end else begin
      y_sat = ff_sh[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                             : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // accumulators and per-word data
  always_ff @(posedge clk) begin
    case (state)
      bqdf2_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx    <= in_idx;
          chan   <= s_axis_tuser;
          acc_fb <= ({{(ACC_W-SAMPLE_BITS){in_x[SAMPLE_BITS-1]}}, in_x}
                     <<< COEF_FRAC_BITS) + ROUND_C;
        end
      end
      bqdf2_pkg::ST_FB1: begin
        w1 <= w1_rd;
        w2 <= w2_rd;
      end
      bqdf2_pkg::ST_FB2: acc_fb <= acc_fb - prod_ext;
      bqdf2_pkg::ST_FF1: acc_fb <= acc_fb - prod_ext;
      bqdf2_pkg::ST_FF2: begin
        w      <= w_sat;
        acc_ff <= ROUND_C + prod_ext;
      end
      bqdf2_pkg::ST_FF0:   acc_ff <= acc_ff + prod_ext;
      bqdf2_pkg::ST_DRAIN: acc_ff <= acc_ff + prod_ext;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bqdf2_pkg::ST_IDLE;
    end else begin
      case (state)
        bqdf2_pkg::ST_IDLE:  if (in_acc) state <= bqdf2_pkg::ST_FB1;
        bqdf2_pkg::ST_FB1:   state <= bqdf2_pkg::ST_FB2;
        bqdf2_pkg::ST_FB2:   state <= bqdf2_pkg::ST_FF1;
        bqdf2_pkg::ST_FF1:   state <= bqdf2_pkg::ST_FF2;
        bqdf2_pkg::ST_FF2:   state <= bqdf2_pkg::ST_FF0;
        bqdf2_pkg::ST_FF0:   state <= bqdf2_pkg::ST_DRAIN;
        bqdf2_pkg::ST_DRAIN: state <= bqdf2_pkg::ST_OUT;
        bqdf2_pkg::ST_OUT:   if (out_free) state <= bqdf2_pkg::ST_IDLE;
        default:             state <= bqdf2_pkg::ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == bqdf2_pkg::ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bqdf2_pkg::ST_OUT && out_free) begin
      y_q          <= y_sat;
      m_axis_tuser <= chan;
    end
  end

  assign m_axis_tdata = TDATA_W'(y_q);

  // checks
  a_wb_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> ##5 (state == bqdf2_pkg::ST_FF0))
    else $error("delay write-back not five cycles after accept");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == bqdf2_pkg::ST_OUT))
    else $error("output loaded outside the output state");

  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(dvalid) >= $past($countones(dvalid))))
    else $error("delay valid bit lost without reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == bqdf2_pkg::ST_OUT && m_axis_tvalid && !m_axis_tready)
      |=> (state == bqdf2_pkg::ST_OUT))
    else $error("result advanced while output stalled");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for biquad_direct_form_two_filter_unit (direct form II biquad).
// A directed table runs first, then random coefficient sets and samples, checked against
// table values or an in-bench fixed-point predictor. Depends on bqdf2_pkg and unit RTL.
module tb_top;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 28;
  localparam int CHANNELS       = 2;
  localparam int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDLE_PCT       = 19;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 3000;
  localparam int RANDOM_WORDS   = 2000;

  // Clamp bounds of the recursion word and of the output sample
  localparam logic signed [67:0] W_MAX = (68'sd1 <<< 31) - 68'sd1;
  localparam logic signed [67:0] W_MIN = -(68'sd1 <<< 31);
  localparam logic signed [67:0] Y_MAX = (68'sd1 <<< (SAMPLE_BITS - 1)) - 68'sd1;
  localparam logic signed [67:0] Y_MIN = -(68'sd1 <<< (SAMPLE_BITS - 1));

  typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

  typedef struct {
    row_kind_t       kind;
    logic [2:0]      idx;
    logic [31:0]     value;  // register data, or the sample in the low bits
    logic            ch;
    bit              typed;  // want holds a hand-written expected sample
    logic [23:0]     want;
  } row_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   chan;
  } filtered_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_we    = 1'b0;
  logic [bqdf2_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bqdf2_pkg::COEF_W-1:0]    cfg_data  = '0;

  logic                         s_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [DATA_W-1:0]            s_tdata  = '0;  // sample_in
  logic [bqdf2_pkg::CHAN_W-1:0] s_tuser  = '0;  // channel_in

  logic                         m_axis_tvalid;
  logic                         m_tready = 1'b0;
  logic [DATA_W-1:0]            m_axis_tdata;   // sample_out
  logic [bqdf2_pkg::CHAN_W-1:0] m_axis_tuser;   // channel_out

  // Predictor copy of coefficients and per-channel delay words
  logic signed [31:0] b0_q = 32'sh1000_0000;
  logic signed [31:0] b1_q = '0;
  logic signed [31:0] b2_q = '0;
  logic signed [31:0] a1_q = '0;
  logic signed [31:0] a2_q = '0;
  logic signed [31:0] w1_q [CHANNELS] = '{default: '0};
  logic signed [31:0] w2_q [CHANNELS] = '{default: '0};

  filtered_t pending_out [$];
  row_t      plan [$];

  int  errors        = 0;
  int  out_count     = 0;
  int  stall_cycles  = 0;
  bit  steady        = 1'b0;  // no idling on either side
  bit  hold_request  = 1'b0;

  biquad_direct_form_two_filter_unit #(
    .CHANNELS       (CHANNELS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Exact signed product in the wide accumulator width
  function automatic logic signed [67:0] coef_times(input logic signed [31:0] c,
                                                    input logic signed [31:0] d);
    logic signed [67:0] cw, dw;
    cw = c;
    dw = d;
    return cw * dw;
  endfunction

  // Round half up at the coefficient point, then clamp
  function automatic logic signed [67:0] round_clamp(input logic signed [67:0] acc,
                                                     input logic signed [67:0] lo,
                                                     input logic signed [67:0] hi);
    logic signed [67:0] v;
    v = (acc + (68'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One filter step on the predictor state; returns the filtered sample
  function automatic logic [SAMPLE_BITS-1:0] biquad_predict(input logic [SAMPLE_BITS-1:0] x,
                                                             input logic ch);
    logic signed [67:0] xw, acc;
    logic signed [31:0] w1, w2, w;
    logic signed [67:0] y;
    xw  = $signed(x);
    w1  = w1_q[ch];
    w2  = w2_q[ch];
    acc = (xw <<< COEF_FRAC_BITS) - coef_times(a1_q, w1) - coef_times(a2_q, w2);
    w   = 32'(round_clamp(acc, W_MIN, W_MAX));
    acc = coef_times(b0_q, w) + coef_times(b1_q, w1) + coef_times(b2_q, w2);
    y   = round_clamp(acc, Y_MIN, Y_MAX);
    w2_q[ch] = w1;
    w1_q[ch] = w;
    return y[SAMPLE_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] word %0d %s: got %0d, want %0d", $time, out_count, what, got, want);
  endtask

  // Register write, only once every expected word has come out
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    s_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      bqdf2_pkg::REG_B0: b0_q = v;
      bqdf2_pkg::REG_B1: b1_q = v;
      bqdf2_pkg::REG_B2: b2_q = v;
      bqdf2_pkg::REG_A1: a1_q = v;
      bqdf2_pkg::REG_A2: a2_q = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one word, wait for the handshake, queue its expected result
  task automatic send_word(input logic [SAMPLE_BITS-1:0] smp, input logic ch,
                           input bit typed, input logic [SAMPLE_BITS-1:0] want);
    filtered_t e;
    logic [SAMPLE_BITS-1:0] y;
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= ch;
    do @(posedge clk); while (!s_axis_tready);
    y = biquad_predict(smp, ch);
    e.sample = typed ? want : y;
    e.chan   = ch;
    pending_out.push_back(e);
  endtask

  // New coefficient set: mostly stable filters, sometimes full range or extremes
  task automatic load_coefs();
    longint a1v, a2v, a1lim;
    logic [31:0] v [5];
    case ($urandom_range(9))
      0, 1: begin
        foreach (v[i]) v[i] = $urandom();
      end
      2: begin
        foreach (v[i]) v[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      default: begin
        a2v   = longint'($urandom_range(0, 483183820)) - 241591910;
        a1lim = ((268435456 + a2v) * 95) / 100;
        a1v   = longint'($urandom_range(0, 32'(2 * a1lim))) - a1lim;
        v[0]  = 32'(longint'($urandom_range(0, 536870912)) - 268435456);
        v[1]  = 32'(longint'($urandom_range(0, 1073741824)) - 536870912);
        v[2]  = 32'(longint'($urandom_range(0, 536870912)) - 268435456);
        v[3]  = 32'(a1v);
        v[4]  = 32'(a2v);
      end
    endcase
    write_reg(bqdf2_pkg::REG_B0, v[0]);
    write_reg(bqdf2_pkg::REG_B1, v[1]);
    write_reg(bqdf2_pkg::REG_B2, v[2]);
    write_reg(bqdf2_pkg::REG_A1, v[3]);
    write_reg(bqdf2_pkg::REG_A2, v[4]);
    // unused indexes must not disturb anything
    if ($urandom_range(3) == 0)
      write_reg(bqdf2_pkg::REG_A2 + 3'd1 + 3'($urandom_range(2)), $urandom());
  endtask

  // Stimulus: directed table, then random phases
  initial begin : stimulus
    row_t r;
    int sent;
    int phase;
    int n_words;
    logic [SAMPLE_BITS-1:0] smp;

    // after reset b0 = 1.0 and the rest 0, so every output equals its input
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h007F_FFFF, 1'b0, 1'b1, 24'h7F_FFFF});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0080_0000, 1'b1, 1'b1, 24'h80_0000});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0000_0000, 1'b0, 1'b1, 24'h00_0000});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h00FF_FFFF, 1'b1, 1'b1, 24'hFF_FFFF});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0000_0001, 1'b0, 1'b1, 24'h00_0001});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0055_5555, 1'b1, 1'b1, 24'h55_5555});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h00AA_AAAA, 1'b0, 1'b1, 24'hAA_AAAA});
    // writes to unused indexes are dropped, so the identity filter stays
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_A2 + 3'd1, 32'h0000_0000, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_A2 + 3'd2, 32'hFFFF_FFFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_A2 + 3'd3, 32'h8000_0000, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0012_3456, 1'b1, 1'b1, 24'h12_3456});
    // extreme coefficients: recursion and output both saturate
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_B0, 32'h7FFF_FFFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_A1, 32'h8000_0000, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_A2, 32'h8000_0000, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h007F_FFFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h007F_FFFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h007F_FFFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0080_0000, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0080_0000, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0080_0000, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0080_0000, 1'b0, 1'b0, '0});
    // opposite extremes on the other taps
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_B1, 32'h8000_0000, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_B2, 32'h7FFF_FFFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_A1, 32'h7FFF_FFFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, bqdf2_pkg::REG_A2, 32'h7FFF_FFFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h007F_FFFF, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0080_0000, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h0000_0001, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_SAMPLE, bqdf2_pkg::REG_B0, 32'h00FF_FFFF, 1'b1, 1'b0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_WRITE) write_reg(r.idx, r.value);
      else send_word(r.value[SAMPLE_BITS-1:0], r.ch, r.typed, r.want);
    end

    // random phases, each with its own coefficient set
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      load_coefs();
      steady  = (phase == 2);
      n_words = $urandom_range(60, 250);
      for (int k = 0; k < n_words; k++) begin
        if (phase == 1 && k == 20) hold_request = 1'b1;
        case ($urandom_range(9))
          0: begin
            case ($urandom_range(3))
              0: smp = 24'h7F_FFFF;
              1: smp = 24'h80_0000;
              2: smp = 24'h00_0000;
              default: smp = 24'hFF_FFFF;
            endcase
          end
          1: smp = 24'($signed(9'($urandom_range(511))));
          default: smp = 24'($urandom());
        endcase
        send_word(smp, 1'($urandom_range(1)), 1'b0, '0);
        sent++;
      end
      phase++;
    end
    steady = 1'b0;

    // drain, then allow for the pipeline latency
    s_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Output ready: random idling, one long hold-off while input keeps coming
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin : check_output
    filtered_t want;
    if (!rst && m_axis_tvalid && m_tready) begin
      if (pending_out.size() == 0) begin
        report_mismatch("unexpected word, sample", $signed(m_axis_tdata[SAMPLE_BITS-1:0]), 0);
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.sample)
          report_mismatch("sample_out", $signed(m_axis_tdata[SAMPLE_BITS-1:0]),
                          $signed(want.sample));
        if (m_axis_tuser[0] !== want.chan)
          report_mismatch("channel_out", m_axis_tuser[0], want.chan);
      end
      out_count++;
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
rtl/bqdf2_pkg.sv
rtl/biquad_direct_form_two_filter_unit.sv
tb/tb_top.sv
